// ===== rtl/bamlps_pkg.sv =====
// Package: shared types and constants of the bit angle modulation plane sequencer
`default_nettype none
package bamlps_pkg;

  localparam int PLANES_DEF    = 10;
  localparam int BYTES_DEF     = 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam int MODE_W        = 2;
  localparam int PLANE_FW      = 4;
  localparam int SLOT_FW       = 3;
  localparam int BYTE_W        = 8;
  localparam int DUR_W         = 16;

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BYTE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUR  = 2'd2;

  typedef enum logic {
    CMD_BURST = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic                  buf_sel;
    logic [PLANE_FW-1:0]   plane;
    logic [SLOT_FW-1:0]    slot;
    logic [BYTE_W-1:0]     data;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/bamlps_if.sv =====
// Interfaces: request and result channels of the plane sequencer
`default_nettype none
interface bamlps_in_if
  import bamlps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic                buffer_id;
  logic [PLANE_FW-1:0] plane;
  logic [SLOT_FW-1:0]  byte_slot;
  logic [BYTE_W-1:0]   byte_value;
  logic [DUR_W-1:0]    duration_value;
  logic                next_buffer;
  logic                hold_swap;

  modport source (output valid, mode, buffer_id, plane, byte_slot, byte_value,
                  duration_value, next_buffer, hold_swap, input ready);
  modport sink   (input valid, mode, buffer_id, plane, byte_slot, byte_value,
                  duration_value, next_buffer, hold_swap, output ready);
endinterface

interface bamlps_out_if
  import bamlps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   shift_byte;
  logic [PLANE_FW-1:0] plane_shown;
  logic                latch_now;

  modport source (output valid, shift_byte, plane_shown, latch_now, input ready);
  modport sink   (input valid, shift_byte, plane_shown, latch_now, output ready);
endinterface
`default_nettype wire

// ===== rtl/bamlps_ram.sv =====
// Generic single write, single read RAM with registered read data
`default_nettype none
module bamlps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bamlps_front.sv =====
// Front end: accept requests, run countdown and plane sequencing, queue commands
`default_nettype none
module bamlps_front
  import bamlps_pkg::*;
#(
  parameter int PLANES          = PLANES_DEF,
  parameter int BYTES_PER_PLANE = BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bamlps_in_if.sink  in_ch,
  output      cmd_t  push_cmd,
  output      logic  push_v,
  input  wire logic  q_full
);

  localparam int PW = $clog2(PLANES);

  logic [DUR_W-1:0] countdown_r, countdown_nxt;
  logic [PW-1:0]    plane_idx_r, plane_idx_nxt;
  logic             act_buf_r, act_buf_nxt;
  logic [DUR_W-1:0] dur_r [PLANES];
  logic             dur_we;
  logic             acc;
  logic             plane_ok;
  logic             slot_ok;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign plane_ok    = 32'(in_ch.plane) < PLANES;
  assign slot_ok     = 32'(in_ch.byte_slot) < BYTES_PER_PLANE;

  always_comb begin
    countdown_nxt    = countdown_r;
    plane_idx_nxt    = plane_idx_r;
    act_buf_nxt      = act_buf_r;
    dur_we           = 1'b0;
    push_v           = 1'b0;
    push_cmd.kind    = CMD_BURST;
    push_cmd.buf_sel = act_buf_r;
    push_cmd.plane   = PLANE_FW'(plane_idx_r);
    push_cmd.slot    = in_ch.byte_slot;
    push_cmd.data    = in_ch.byte_value;
    if (acc) begin
      unique case (in_ch.mode)
        MODE_TICK: begin
          if (countdown_r != '0) begin
            countdown_nxt = countdown_r - DUR_W'(1);
          end else begin
            push_v        = 1'b1;
            countdown_nxt = dur_r[plane_idx_r];
            if (plane_idx_r == PW'(PLANES - 1)) begin
              plane_idx_nxt = '0;
              if (!in_ch.hold_swap) begin
                act_buf_nxt = in_ch.next_buffer;
              end
            end else begin
              plane_idx_nxt = plane_idx_r + PW'(1);
            end
          end
        end
        MODE_BYTE: begin
          push_v           = plane_ok && slot_ok;
          push_cmd.kind    = CMD_WRITE;
          push_cmd.buf_sel = in_ch.buffer_id;
          push_cmd.plane   = in_ch.plane;
        end
        MODE_DUR: begin
          dur_we = plane_ok;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= '0;
      plane_idx_r <= '0;
      act_buf_r   <= 1'b0;
      for (int i = 0; i < PLANES; i++) begin
        dur_r[i] <= '0;
      end
    end else begin
      countdown_r <= countdown_nxt;
      plane_idx_r <= plane_idx_nxt;
      act_buf_r   <= act_buf_nxt;
      if (dur_we) begin
        dur_r[in_ch.plane[PW-1:0]] <= in_ch.duration_value;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bamlps_queue.sv =====
// Command queue between front end and burst engine
`default_nettype none
module bamlps_queue
  import bamlps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_v,
  input  wire cmd_t push_cmd,
  output      logic full,
  output      logic head_v,
  output      cmd_t head_cmd,
  input  wire logic pop
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  cmd_t          ent_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QW:0]   cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = cnt_r == (QW+1)'(QUEUE_DEPTH);
  assign head_v   = cnt_r != '0;
  assign head_cmd = ent_r[rd_ptr_r];
  assign do_push  = push_v && !full;
  assign do_pop   = pop && head_v;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QW+1)'(do_push) - (QW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bamlps_back.sv =====
// Burst engine: frame store writes and byte bursts to the output channel
`default_nettype none
module bamlps_back
  import bamlps_pkg::*;
#(
  parameter int PLANES          = PLANES_DEF,
  parameter int BYTES_PER_PLANE = BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   head_v,
  input  wire cmd_t   head_cmd,
  output      logic   pop,
  bamlps_out_if.source out_ch
);

  localparam int PLANE_BYTES = PLANES * BYTES_PER_PLANE;
  localparam int DEPTH       = 2 * PLANE_BYTES;
  localparam int AW          = $clog2(DEPTH);
  localparam int SW          = (BYTES_PER_PLANE > 1) ? $clog2(BYTES_PER_PLANE) : 1;

  logic [DEPTH-1:0]    vld_r;
  logic [SW-1:0]       cnt_r, cnt_nxt;
  logic                s1_v_r, s1_v_nxt;
  logic                s1_vld_r;
  logic [PLANE_FW-1:0] s1_plane_r;
  logic                s1_last_r;
  logic                out_v_r, out_v_nxt;
  logic [BYTE_W-1:0]   out_byte_r;
  logic [PLANE_FW-1:0] out_plane_r;
  logic                out_last_r;
  logic [BYTE_W-1:0]   rd_data;
  logic                is_burst;
  logic                is_write;
  logic                move;
  logic                rd_en;
  logic                last_slot;
  logic [SW-1:0]       slot_sel;
  logic [AW-1:0]       addr;

  assign is_burst  = head_v && (head_cmd.kind == CMD_BURST);
  assign is_write  = head_v && (head_cmd.kind == CMD_WRITE);
  assign move      = s1_v_r && (!out_v_r || out_ch.ready);
  assign rd_en     = is_burst && (!s1_v_r || move);
  assign last_slot = cnt_r == SW'(BYTES_PER_PLANE - 1);
  assign pop       = is_write || (rd_en && last_slot);
  assign slot_sel  = is_write ? SW'(head_cmd.slot) : cnt_r;
  assign addr      = (head_cmd.buf_sel ? AW'(PLANE_BYTES) : AW'(0))
                   + AW'(head_cmd.plane) * AW'(BYTES_PER_PLANE) + AW'(slot_sel);

  always_comb begin
    cnt_nxt = cnt_r;
    if (rd_en) begin
      cnt_nxt = last_slot ? '0 : cnt_r + SW'(1);
    end
    s1_v_nxt = rd_en || (s1_v_r && !move);
    out_v_nxt = move || (out_v_r && !out_ch.ready);
  end

  bamlps_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (is_write),
    .waddr (addr),
    .wdata (head_cmd.data),
    .re    (rd_en),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (is_write) begin
        vld_r[addr] <= 1'b1;
      end
      cnt_r   <= cnt_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_vld_r   <= vld_r[addr];
      s1_plane_r <= head_cmd.plane;
      s1_last_r  <= last_slot;
    end
    if (move) begin
      out_byte_r  <= s1_vld_r ? rd_data : '0;
      out_plane_r <= s1_plane_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.shift_byte  = out_byte_r;
  assign out_ch.plane_shown = out_plane_r;
  assign out_ch.latch_now   = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/bam_led_plane_sequencer_unit.sv =====
// Top level: bit angle modulation plane sequencer for shift-register LED chains
//
// in_ch carries one request per handshake: a timer tick, a frame byte write
// or a plane duration write. A request is taken whenever the command queue
// has room, so ticks and writes go in at one per cycle.
// A tick that finds the countdown at zero starts a burst: BYTES_PER_PLANE
// results on out_ch, one per cycle while out_ch.ready is high, the last
// with latch_now set. The first byte passes the command queue, the RAM read
// stage and the output register. The frame RAM's single read port gives one
// byte a cycle unless out_ch stalls; a frame byte write also occupies the engine.
// Up to four bursts or frame writes wait in the queue; with the queue full,
// in_ch.ready drops until the burst engine frees a slot.
// When out_ch.ready is low the current byte holds on out_ch and the burst
// engine pauses; the front end keeps taking requests until the queue fills.
// Synchronous reset (rst_n low) clears the frame store valid bits (unwritten
// bytes read as zero), durations, plane index, active buffer and countdown and
// empties the queue; no clearing pass is needed, so requests are taken on the first cycle after reset.
`default_nettype none
module bam_led_plane_sequencer_unit
  import bamlps_pkg::*;
#(
  parameter int PLANES          = PLANES_DEF,
  parameter int BYTES_PER_PLANE = BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bamlps_in_if.sink    in_ch,
  bamlps_out_if.source out_ch
);

  cmd_t push_cmd;
  logic push_v;
  logic q_full;
  logic head_v;
  cmd_t head_cmd;
  logic pop;

  bamlps_front #(
    .PLANES          (PLANES),
    .BYTES_PER_PLANE (BYTES_PER_PLANE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push_cmd (push_cmd),
    .push_v   (push_v),
    .q_full   (q_full)
  );

  bamlps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_v   (push_v),
    .push_cmd (push_cmd),
    .full     (q_full),
    .head_v   (head_v),
    .head_cmd (head_cmd),
    .pop      (pop)
  );

  bamlps_back #(
    .PLANES          (PLANES),
    .BYTES_PER_PLANE (BYTES_PER_PLANE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_v   (head_v),
    .head_cmd (head_cmd),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
